// ===== sv/pss_pkg.sv =====
package pss_pkg;

	localparam int NUM_KEYS_DEF = 12;

	localparam int KEY_W      = 4;
	localparam int MASK_W     = 12;
	localparam int ACC_W      = 32;
	localparam int SUM_W      = 12;
	localparam int SAMPLE_W   = 12;
	localparam int WEIGHT_W   = 4;
	localparam int TOP_W      = 8;

	localparam int LEVEL_W    = 5;
	localparam int OCT_W      = 4;
	localparam int MODE_W     = 2;
	localparam int SET_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_SETTING = 2'd3;

	localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW_PASS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH_PASS = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_RST   = 5'd12;
	localparam logic [OCT_W-1:0]   OCTAVE_RST  = 4'd4;
	localparam logic [MODE_W-1:0]  MODE_RST    = MODE_PLAIN;
	localparam logic [SET_W-1:0]   SETTING_RST = 4'd0;

	localparam logic [OCT_W-1:0]  OCT_CENTRE   = 4'd4;
	localparam logic [MASK_W-1:0] ALL_RELEASED = 12'hFFF;
	localparam logic [ACC_W-1:0]  STEP_MULT    = 32'd195225;

	// Division by ten as a multiply by the rounded-up reciprocal, exact for 32-bit values.
	localparam logic [2*ACC_W-1:0] RECIP_10    = 64'h0000_0000_CCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

	localparam logic signed [6:0] LPF_BIAS   = 7'sd18;
	localparam logic signed [6:0] HPF_BIAS   = 7'sd7;
	localparam logic signed [6:0] WEIGHT_MIN = 7'sd1;
	localparam logic signed [6:0] WEIGHT_MAX = 7'sd10;

	localparam logic [3:0]          FULL_SHIFT  = 4'd8;
	localparam logic signed [SUM_W-1:0] SAMPLE_BIAS = 12'sd128;

	typedef struct packed {
		logic [LEVEL_W-1:0] output_level;
		logic [OCT_W-1:0]   octave_shift;
		logic [MODE_W-1:0]  tone_mode;
		logic [SET_W-1:0]   tone_setting;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] voice;
		logic [ACC_W-1:0] step;
	} step_word_t;

	typedef struct packed {
		logic             busy;
		logic [KEY_W-1:0] count;
	} key_list_status_t;

	function automatic logic [8:0] base_step(input logic [KEY_W-1:0] key);
		logic [8:0] b;
		unique case (key)
			4'd0, 4'd12: b = 9'd262;
			4'd1, 4'd13: b = 9'd277;
			4'd2, 4'd14: b = 9'd294;
			4'd3, 4'd15: b = 9'd311;
			4'd4:        b = 9'd330;
			4'd5:        b = 9'd349;
			4'd6:        b = 9'd370;
			4'd7:        b = 9'd392;
			4'd8:        b = 9'd415;
			4'd9:        b = 9'd440;
			4'd10:       b = 9'd466;
			4'd11:       b = 9'd494;
		endcase
		return b;
	endfunction

	function automatic logic [ACC_W-1:0] shifted_base(input logic [KEY_W-1:0] key,
		input logic [OCT_W-1:0] octave);
		logic [ACC_W-1:0] base;
		logic [ACC_W-1:0] res;
		base = ACC_W'(base_step(key));
		if (octave >= OCT_CENTRE) begin
			res = base << (octave - OCT_CENTRE);
		end else begin
			res = base >> (OCT_CENTRE - octave);
		end
		return res;
	endfunction

	function automatic logic [WEIGHT_W-1:0] tone_weight(input logic [MODE_W-1:0] mode,
		input logic [SET_W-1:0] setting, input logic [KEY_W-1:0] key);
		logic signed [6:0] w;
		logic [WEIGHT_W-1:0] res;
		if (mode == MODE_LOW_PASS) begin
			w = LPF_BIAS - $signed({3'b000, setting}) - $signed({3'b000, key});
		end else begin
			w = $signed({3'b000, key}) + HPF_BIAS - $signed({3'b000, setting});
		end
		if (w < WEIGHT_MIN) begin
			res = WEIGHT_W'(WEIGHT_MIN);
		end else if (w > WEIGHT_MAX) begin
			res = WEIGHT_W'(WEIGHT_MAX);
		end else begin
			res = w[WEIGHT_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== sv/pss_ifs.sv =====
interface pss_cmd_if import pss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [MASK_W-1:0] key_mask;

	modport source (output valid, output operation, output key_mask, input ready);
	modport sink   (input valid, input operation, input key_mask, output ready);
endinterface

interface pss_smp_if import pss_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface pss_cfg_if import pss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pss_key_list.sv =====
module pss_key_list import pss_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan_valid,
	input  logic [MASK_W-1:0] scan_mask,
	input  logic             rd_en,
	input  logic [KEY_W-1:0] rd_voice,
	output logic [KEY_W-1:0] rd_key,
	output key_list_status_t status
);

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [KEY_W-1:0] LAST_BIT = KEY_W'(NUM_KEYS - 1);

	logic [KEY_W-1:0] key_mem [NUM_KEYS];

	logic [MASK_W-1:0] prev_mask_q;
	logic [MASK_W-1:0] mask_q;
	logic [KEY_W-1:0]  bit_q;
	logic [KEY_W-1:0]  fill_q;
	logic [KEY_W-1:0]  count_q;
	logic              busy_q;
	logic [KEY_W-1:0]  rd_key_q;
	logic              pressed;

	// Mask bits are active low.
	assign pressed = ~mask_q[bit_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mask_q <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			bit_q       <= '0;
			fill_q      <= '0;
		end else if (scan_valid) begin
			if (scan_mask == ALL_RELEASED) begin
				prev_mask_q <= ALL_RELEASED;
				count_q     <= '0;
			end else if (scan_mask != prev_mask_q) begin
				prev_mask_q <= scan_mask;
				busy_q      <= 1'b1;
				bit_q       <= '0;
				fill_q      <= '0;
			end
		end else if (busy_q) begin
			if (pressed) begin
				fill_q <= fill_q + 1'b1;
			end
			if (bit_q == LAST_BIT) begin
				busy_q  <= 1'b0;
				count_q <= fill_q + KEY_W'(pressed);
			end
			bit_q <= bit_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid) begin
			mask_q <= scan_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && pressed) begin
			key_mem[fill_q[AW-1:0]] <= bit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_voice[AW-1:0]];
		end
	end

	assign rd_key       = rd_key_q;
	assign status.busy  = busy_q;
	assign status.count = count_q;

endmodule

// ===== sv/pss_step_calc.sv =====
module pss_step_calc import pss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             issue_valid,
	input  logic [KEY_W-1:0] issue_voice,
	input  logic [KEY_W-1:0] key_rdata,
	output step_word_t       step_out,
	output logic             busy
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [KEY_W-1:0] voice_s1, voice_s2, voice_s3, voice_s4;
	logic [KEY_W-1:0] key_s2, key_s3;
	logic [ACC_W-1:0] prod_s2;
	logic [ACC_W-1:0] plain_s3;
	logic [ACC_W-1:0] quot_s3;
	logic [ACC_W-1:0] step_s4;
	logic [2*ACC_W-1:0] recip;
	logic filtered;

	assign recip    = {{ACC_W{1'b0}}, prod_s2} * RECIP_10;
	assign filtered = (cfg.tone_mode == MODE_LOW_PASS) || (cfg.tone_mode == MODE_HIGH_PASS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// The key memory answers in the cycle after the issue, in line with stage one.
	always_ff @(posedge clk) begin
		voice_s1 <= issue_voice;
		voice_s2 <= voice_s1;
		key_s2   <= key_rdata;
		prod_s2  <= shifted_base(key_rdata, cfg.octave_shift) * STEP_MULT;
		voice_s3 <= voice_s2;
		key_s3   <= key_s2;
		plain_s3 <= prod_s2;
		quot_s3  <= ACC_W'(recip >> RECIP_SHIFT);
		voice_s4 <= voice_s3;
		if (filtered) begin
			step_s4 <= quot_s3 * ACC_W'(tone_weight(cfg.tone_mode, cfg.tone_setting, key_s3));
		end else begin
			step_s4 <= plain_s3;
		end
	end

	assign step_out.valid = v_s4;
	assign step_out.voice = voice_s4;
	assign step_out.step  = step_s4;
	assign busy           = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

// ===== sv/pss_phase_acc.sv =====
module pss_phase_acc import pss_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  step_word_t              step_in,
	input  logic                    sum_clr,
	output logic signed [SUM_W-1:0] sum,
	output logic                    busy
);

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [ACC_W-1:0]    acc_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] acc_valid_q;

	logic             v_s5, v_s6;
	logic [KEY_W-1:0] voice_s5;
	logic [ACC_W-1:0] step_s5;
	logic [ACC_W-1:0] rdata_s5;
	logic             hit_s5;
	logic [ACC_W-1:0] acc_new;
	logic signed [TOP_W-1:0] top_s6;
	logic signed [SUM_W-1:0] sum_q;

	// An entry never written since reset reads as zero.
	assign acc_new = (hit_s5 ? rdata_s5 : '0) + step_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			acc_valid_q <= '0;
			sum_q       <= '0;
		end else begin
			v_s5 <= step_in.valid;
			v_s6 <= v_s5;
			if (v_s5) begin
				acc_valid_q[voice_s5[AW-1:0]] <= 1'b1;
			end
			if (sum_clr) begin
				sum_q <= '0;
			end else if (v_s6) begin
				sum_q <= sum_q + {{(SUM_W-TOP_W){top_s6[TOP_W-1]}}, top_s6};
			end
		end
	end

	// Each voice is touched once per tick and ticks never overlap, so the
	// read of one voice cannot meet a pending write of the same voice.
	always_ff @(posedge clk) begin
		if (step_in.valid) begin
			rdata_s5 <= acc_mem[step_in.voice[AW-1:0]];
		end
		hit_s5   <= acc_valid_q[step_in.voice[AW-1:0]];
		voice_s5 <= step_in.voice;
		step_s5  <= step_in.step;
		top_s6   <= acc_new[ACC_W-1 -: TOP_W];
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			acc_mem[voice_s5[AW-1:0]] <= acc_new;
		end
	end

	assign sum  = sum_q;
	assign busy = v_s5 | v_s6;

endmodule

// ===== sv/polyphonic_sawtooth_synth_unit.sv =====
// Channel  Dir  Word
// cmd      in   operation (0 scan, 1 tick), key_mask (active low)
// smp      out  sample, one word per tick
// cfg      in   index, data; always ready
//
// A scan ends once the key list is idle, after any rebuild of the voice list by the mask.
// In a tick, one voice per cycle is issued into a six-stage pipe around the phase
// memory, then the sum is scaled and registered.
// Reset restores the configuration defaults and clears the voice list and phase valid bits at once; no sweep.
// A new word is taken while a finished sample waits; a tick stalls only at its end.
module polyphonic_sawtooth_synth_unit import pss_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	pss_cmd_if.sink  cmd,
	pss_smp_if.source smp,
	pss_cfg_if.sink  cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TICK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	cfg_t             cfg_q;
	logic [KEY_W-1:0] voice_q;
	logic             smp_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic             accept;
	logic             scan_start;
	logic             issue;
	logic             load;
	logic             step_busy;
	logic             phase_busy;
	logic [KEY_W-1:0] key_rdata;
	key_list_status_t kl_status;
	step_word_t       step_word;
	logic signed [SUM_W-1:0] sum;
	logic [3:0]       half_level;
	logic [3:0]       shift;
	logic signed [SUM_W-1:0] scaled;

	assign accept     = cmd.valid && cmd.ready;
	assign scan_start = accept && (cmd.operation == OP_SCAN);
	assign issue      = (state_q == ST_TICK) && (voice_q < kl_status.count);
	assign load       = (state_q == ST_DONE) && (!smp_valid_q || smp.ready);

	assign half_level = cfg_q.output_level[LEVEL_W-1:1];
	assign shift      = (half_level >= FULL_SHIFT) ? 4'd0 : FULL_SHIFT - half_level;
	assign scaled     = (sum >>> shift) + SAMPLE_BIAS;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign smp.valid  = smp_valid_q;
	assign smp.sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_level <= LEVEL_RST;
			cfg_q.octave_shift <= OCTAVE_RST;
			cfg_q.tone_mode    <= MODE_RST;
			cfg_q.tone_setting <= SETTING_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OUTPUT_LEVEL: cfg_q.output_level <= cfg.data;
				CFG_OCTAVE_SHIFT: cfg_q.octave_shift <= cfg.data[OCT_W-1:0];
				CFG_TONE_MODE:    cfg_q.tone_mode    <= cfg.data[MODE_W-1:0];
				CFG_TONE_SETTING: cfg_q.tone_setting <= cfg.data[SET_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			voice_q     <= '0;
			smp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				smp_valid_q <= 1'b1;
			end else if (smp.ready) begin
				smp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						voice_q <= '0;
						state_q <= (cmd.operation == OP_TICK) ? ST_TICK : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!kl_status.busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (issue) begin
						voice_q <= voice_q + 1'b1;
					end else if (!step_busy && !phase_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= scaled;
		end
	end

	pss_key_list #(
		.NUM_KEYS(NUM_KEYS)
	) u_key_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_valid(scan_start),
		.scan_mask (cmd.key_mask),
		.rd_en     (issue),
		.rd_voice  (voice_q),
		.rd_key    (key_rdata),
		.status    (kl_status)
	);

	pss_step_calc u_step_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.issue_valid(issue),
		.issue_voice(voice_q),
		.key_rdata  (key_rdata),
		.step_out   (step_word),
		.busy       (step_busy)
	);

	pss_phase_acc #(
		.NUM_KEYS(NUM_KEYS)
	) u_phase_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.step_in(step_word),
		.sum_clr(accept && (cmd.operation == OP_TICK)),
		.sum    (sum),
		.busy   (phase_busy)
	);

endmodule

// ===== tb/polyphonic_sawtooth_synth_unit_test.sv =====
`timescale 1ns / 100ps

module polyphonic_sawtooth_synth_unit_test;
	import pss_pkg::*;

	localparam int INTRO_ROWS      = 25;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 123;
	localparam int SETTLE_CYCLES   = 2 * NUM_KEYS_DEF + 16;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic              op;
		logic [MASK_W-1:0] mask;
		logic              pinned;
		sample_t           want;
	} key_word_t;

	logic clk;
	logic arst_n;

	pss_cmd_if cmd_ch ();
	pss_smp_if smp_ch ();
	pss_cfg_if cfg_ch ();

	polyphonic_sawtooth_synth_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.smp    (smp_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the synth state, advanced on every accepted word.
	logic [ACC_W-1:0]   voice_phase [NUM_KEYS_DEF];
	logic [KEY_W-1:0]   voice_key [NUM_KEYS_DEF];
	int unsigned        voice_total;
	logic [MASK_W-1:0]  latched_mask;
	logic [LEVEL_W-1:0] level_r;
	logic [OCT_W-1:0]   octave_r;
	logic [MODE_W-1:0]  mode_r;
	logic [SET_W-1:0]   setting_r;

	sample_t pending_samples [$];
	int      mismatches;
	int      ticks_seen;
	int      scans_seen;
	int      rebuilds_seen;
	int      samples_checked;
	int      settings_used;

	logic    word_pinned;
	sample_t word_pin_val;
	int      burst_left;
	int      holds_asked;
	int      holds_done;

	key_word_t intro_words [0:INTRO_ROWS-1] = '{
		'{OP_TICK, 12'h000, 1'b1, 12'sd128},
		'{OP_SCAN, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'hFFF, 1'b1, 12'sd128},
		'{OP_SCAN, 12'hFFF, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b1, 12'sd128},
		'{OP_SCAN, 12'hFFE, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'hABC, 1'b0, 12'sd0},
		'{OP_SCAN, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'h543, 1'b0, 12'sd0},
		'{OP_TICK, 12'hFFF, 1'b0, 12'sd0},
		'{OP_SCAN, 12'h7FF, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_SCAN, 12'h7FF, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_SCAN, 12'h5A5, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_SCAN, 12'hA5A, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_SCAN, 12'hFFF, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b1, 12'sd128},
		'{OP_SCAN, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0},
		'{OP_TICK, 12'h000, 1'b0, 12'sd0}
	};

	function automatic logic [ACC_W-1:0] pitch_base(input logic [KEY_W-1:0] key);
		case (key)
			4'd0:    return 32'd262;
			4'd1:    return 32'd277;
			4'd2:    return 32'd294;
			4'd3:    return 32'd311;
			4'd4:    return 32'd330;
			4'd5:    return 32'd349;
			4'd6:    return 32'd370;
			4'd7:    return 32'd392;
			4'd8:    return 32'd415;
			4'd9:    return 32'd440;
			4'd10:   return 32'd466;
			default: return 32'd494;
		endcase
	endfunction

	function automatic logic [ACC_W-1:0] voice_increment(input logic [KEY_W-1:0] key);
		logic [ACC_W-1:0] inc;
		int               w;
		inc = pitch_base(key);
		if (octave_r >= OCT_CENTRE) begin
			inc = inc << (octave_r - OCT_CENTRE);
		end else begin
			inc = inc >> (OCT_CENTRE - octave_r);
		end
		inc = inc * STEP_MULT;
		if (mode_r == MODE_LOW_PASS || mode_r == MODE_HIGH_PASS) begin
			if (mode_r == MODE_LOW_PASS) begin
				w = 18 - int'(setting_r) - int'(key);
			end else begin
				w = int'(key) + 7 - int'(setting_r);
			end
			if (w < 1) w = 1;
			if (w > 10) w = 10;
			inc = (inc / 32'd10) * ACC_W'(w);
		end
		return inc;
	endfunction

	function automatic sample_t synth_tick_sample();
		int acc_sum;
		int sh;
		acc_sum = 0;
		for (int v = 0; v < voice_total; v++) begin
			voice_phase[v] = voice_phase[v] + voice_increment(voice_key[v]);
		end
		for (int v = 0; v < voice_total; v++) begin
			acc_sum += int'($signed(voice_phase[v][ACC_W-1 -: TOP_W]));
		end
		sh = (level_r / 2 >= 8) ? 0 : 8 - level_r / 2;
		acc_sum = (acc_sum >>> sh) + 128;
		return SAMPLE_W'(acc_sum);
	endfunction

	function automatic void apply_key_scan(input logic [MASK_W-1:0] mask);
		int unsigned n;
		n = 0;
		if (mask == ALL_RELEASED) begin
			latched_mask = ALL_RELEASED;
			voice_total = 0;
		end else if (mask != latched_mask) begin
			for (int k = 0; k < NUM_KEYS_DEF; k++) begin
				if (!mask[k]) begin
					voice_key[n] = KEY_W'(k);
					n++;
				end
			end
			voice_total = n;
			latched_mask = mask;
			rebuilds_seen++;
		end
	endfunction

	function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_OUTPUT_LEVEL: level_r = val[LEVEL_W-1:0];
			CFG_OCTAVE_SHIFT: octave_r = val[OCT_W-1:0];
			CFG_TONE_MODE:    mode_r = val[MODE_W-1:0];
			CFG_TONE_SETTING: setting_r = val[SET_W-1:0];
			default: ;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : observe
		sample_t got;
		sample_t want;
		if (cmd_ch.valid && cmd_ch.ready) begin
			if (cmd_ch.operation == OP_TICK) begin
				want = synth_tick_sample();
				if (word_pinned) want = word_pin_val;
				pending_samples.push_back(want);
				ticks_seen++;
			end else begin
				apply_key_scan(cmd_ch.key_mask);
				scans_seen++;
			end
		end
		if (smp_ch.valid && smp_ch.ready) begin
			got = smp_ch.sample;
			if (pending_samples.size() == 0) begin
				$error("sample: no word expected, actual %0d", got);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				samples_checked++;
				if (got !== want) begin
					$error("sample: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		end
		if (cfg_ch.valid && cfg_ch.ready) set_register(cfg_ch.index, cfg_ch.data);
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if ((cmd_ch.valid && cmd_ch.ready) || (smp_ch.valid && smp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// The receiver switches between stall patterns in segments; a requested hold-off
	// keeps ready low for a long stretch so that the block backs up into its input.
	initial begin : sample_sink
		int seg_left;
		int pattern;
		int period;
		int hold_left;
		seg_left = 0;
		pattern = 0;
		period = 2;
		hold_left = 0;
		holds_done = 0;
		smp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_asked > holds_done) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				smp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					pattern = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 200);
					period = $urandom_range(2, 5);
				end
				seg_left--;
				case (pattern)
					0: smp_ch.ready <= 1'b1;
					1: smp_ch.ready <= 1'($urandom_range(0, 1));
					2: smp_ch.ready <= (seg_left % period == 0);
					default: smp_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic op, input logic [MASK_W-1:0] mask,
		input logic pinned, input sample_t pin_val);
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.key_mask <= mask;
		word_pinned <= pinned;
		word_pin_val <= pin_val;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// Bursts of back-to-back words, with a random gap between bursts when asked.
	task automatic pace(input bit gappy);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gappy) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		// A key-list rebuild produces no word, so give it time to finish as well.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [LEVEL_W-1:0] lv;
		logic [OCT_W-1:0]   oc;
		logic [MODE_W-1:0]  md;
		logic [SET_W-1:0]   st;
		logic [MASK_W-1:0]  last_scan;
		logic [MASK_W-1:0]  mask;
		logic               op;
		int                 pick;

		level_r = LEVEL_RST;
		octave_r = OCTAVE_RST;
		mode_r = MODE_RST;
		setting_r = SETTING_RST;
		for (int v = 0; v < NUM_KEYS_DEF; v++) begin
			voice_phase[v] = '0;
			voice_key[v] = '0;
		end
		voice_total = 0;
		latched_mask = '0;
		mismatches = 0;
		ticks_seen = 0;
		scans_seen = 0;
		rebuilds_seen = 0;
		samples_checked = 0;
		settings_used = 1;
		burst_left = 0;
		holds_asked = 0;
		last_scan = '0;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_SCAN;
		cmd_ch.key_mask <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_OUTPUT_LEVEL;
		cfg_ch.data <= '0;
		word_pinned <= 1'b0;
		word_pin_val <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words run under the reset configuration.
		for (int r = 0; r < INTRO_ROWS; r++) begin
			pace(1'b1);
			send_word(intro_words[r].op, intro_words[r].mask, intro_words[r].pinned,
				intro_words[r].want);
		end
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin lv = 5'd0;  oc = 4'd0;  md = MODE_PLAIN;     st = 4'd0;  end
				1: begin lv = 5'd16; oc = 4'd8;  md = MODE_LOW_PASS;  st = 4'd9;  end
				2: begin lv = 5'd31; oc = 4'd15; md = MODE_HIGH_PASS; st = 4'd15; end
				3: begin lv = 5'd12; oc = 4'd4;  md = 2'd3;           st = 4'd0;  end
				4: begin lv = 5'd16; oc = 4'd8;  md = MODE_HIGH_PASS; st = 4'd0;  end
				5: begin lv = 5'd1;  oc = 4'd1;  md = MODE_LOW_PASS;  st = 4'd15; end
				default: begin
					lv = LEVEL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
						: $urandom_range(0, 16));
					oc = OCT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
						: $urandom_range(0, 8));
					md = MODE_W'($urandom_range(0, 3));
					st = SET_W'(($urandom_range(0, 5) == 0) ? $urandom_range(10, 15)
						: $urandom_range(0, 9));
				end
			endcase
			write_reg(CFG_OUTPUT_LEVEL, CFG_DATA_W'(lv));
			write_reg(CFG_OCTAVE_SHIFT, CFG_DATA_W'(oc));
			write_reg(CFG_TONE_MODE, CFG_DATA_W'(md));
			write_reg(CFG_TONE_SETTING, CFG_DATA_W'(st));
			@(negedge clk);
			cfg_ch.valid <= 1'b0;
			settings_used++;

			if (ph == 3) holds_asked++;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 62) begin
					op = OP_TICK;
					mask = MASK_W'($urandom_range(0, 4095));
				end else begin
					op = OP_SCAN;
					pick = $urandom_range(0, 9);
					case (pick)
						0: mask = ALL_RELEASED;
						1: mask = last_scan;
						2: mask = '0;
						3, 4, 5, 6: begin
							mask = ALL_RELEASED;
							mask[$urandom_range(0, NUM_KEYS_DEF - 1)] = 1'b0;
							if ($urandom_range(0, 1)) mask[$urandom_range(0, NUM_KEYS_DEF - 1)] = 1'b0;
							if ($urandom_range(0, 2) == 0) mask[$urandom_range(0, NUM_KEYS_DEF - 1)] = 1'b0;
						end
						default: mask = MASK_W'($urandom_range(0, 4095));
					endcase
					last_scan = mask;
				end
				pace(ph % 3 != 0);
				send_word(op, mask, 1'b0, '0);
			end
			drain();
		end

		if (pending_samples.size() != 0) begin
			$error("sample: %0d expected words never arrived", pending_samples.size());
			mismatches++;
		end
		$display("Run covered %0d ticks and %0d key scans (%0d voice-list rebuilds)",
			ticks_seen, scans_seen, rebuilds_seen);
		$display("across %0d register settings, with %0d samples compared.",
			settings_used, samples_checked);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
